// ===== rtl/rpb_pkg.sv =====
// rpb_pkg: shared types and constants of the RGB16 pixel blender.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package rpb_pkg;

  localparam int NUM_CH = 3;
  localparam int CH_B   = 0;
  localparam int CH_G   = 1;
  localparam int CH_R   = 2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_PIXEL_FORMAT = 2'd0,
    REG_BLEND_MODE   = 2'd1,
    REG_ALPHA_LEVEL  = 2'd2
  } reg_idx_t;

  localparam logic       FMT_565     = 1'b0;
  localparam logic       FMT_555     = 1'b1;
  localparam logic       MODE_ALPHA  = 1'b0;
  localparam logic       MODE_ADD    = 1'b1;
  localparam logic [7:0] ALPHA_RESET = 8'd128;
  localparam logic [5:0] MAX5        = 6'h1F;
  localparam logic [5:0] MAX6        = 6'h3F;

  typedef struct packed {
    logic       pixel_format;
    logic       blend_mode;
    logic [7:0] alpha_level;
  } cfg_t;

  // after stage 1: channels unpacked, difference and sum formed
  typedef struct packed {
    logic                        transparent;
    logic [15:0]                 dst_px;
    logic                        fmt;
    logic                        mode;
    logic [4:0]                  factor;
    logic [NUM_CH-1:0][5:0]      dch;
    logic [NUM_CH-1:0][6:0]      diff;
    logic [NUM_CH-1:0][6:0]      sum;
    logic [NUM_CH-1:0][5:0]      maxv;
  } front_t;

  // after stage 2: scaled difference and saturated sum
  typedef struct packed {
    logic                        transparent;
    logic [15:0]                 dst_px;
    logic                        fmt;
    logic                        mode;
    logic [NUM_CH-1:0][5:0]      dch;
    logic [NUM_CH-1:0][11:0]     prod;
    logic [NUM_CH-1:0][5:0]      sat;
  } mid_t;

endpackage

`default_nettype wire

// ===== rtl/rpb_apb_regs.sv =====
// rpb_apb_regs: APB register file holding format, mode and alpha level.
// Depends on rpb_pkg.
`default_nettype none

module rpb_apb_regs (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [rpb_pkg::ADDR_W-1:0]       paddr,
  input  wire  [rpb_pkg::DATA_W-1:0]       pwdata,
  output logic [rpb_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  output rpb_pkg::cfg_t                    cfg
);

  logic              wr_en;
  rpb_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = rpb_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= rpb_pkg::FMT_565;
      cfg.blend_mode   <= rpb_pkg::MODE_ALPHA;
      cfg.alpha_level  <= rpb_pkg::ALPHA_RESET;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      unique case (idx)
        rpb_pkg::REG_PIXEL_FORMAT: cfg.pixel_format <= pwdata[0];
        rpb_pkg::REG_BLEND_MODE:   cfg.blend_mode   <= pwdata[0];
        rpb_pkg::REG_ALPHA_LEVEL:  cfg.alpha_level  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      rpb_pkg::REG_PIXEL_FORMAT: prdata[0]   = cfg.pixel_format;
      rpb_pkg::REG_BLEND_MODE:   prdata[0]   = cfg.blend_mode;
      rpb_pkg::REG_ALPHA_LEVEL:  prdata[7:0] = cfg.alpha_level;
      default:                   prdata      = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rpb_front.sv =====
// rpb_front: pipeline stage 1, unpacks both pixels and forms per-channel
// difference and sum. Depends on rpb_pkg.
`default_nettype none

module rpb_front (
  input  wire                 clk,
  input  wire                 rst,
  input  rpb_pkg::cfg_t       cfg,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [15:0]         src_px,
  input  wire  [15:0]         dst_px,
  output logic                st_valid,
  input  wire                 st_ready,
  output rpb_pkg::front_t     st
);

  logic [rpb_pkg::NUM_CH-1:0][5:0] sch;
  logic [rpb_pkg::NUM_CH-1:0][5:0] dch;
  rpb_pkg::front_t                 st_next;

  assign in_ready = !st_valid || st_ready;

  always_comb begin
    sch[rpb_pkg::CH_B] = {1'b0, src_px[4:0]};
    dch[rpb_pkg::CH_B] = {1'b0, dst_px[4:0]};
    if (cfg.pixel_format == rpb_pkg::FMT_565) begin
      sch[rpb_pkg::CH_G] = src_px[10:5];
      sch[rpb_pkg::CH_R] = {1'b0, src_px[15:11]};
      dch[rpb_pkg::CH_G] = dst_px[10:5];
      dch[rpb_pkg::CH_R] = {1'b0, dst_px[15:11]};
    end else begin
      sch[rpb_pkg::CH_G] = {1'b0, src_px[9:5]};
      sch[rpb_pkg::CH_R] = {1'b0, src_px[14:10]};
      dch[rpb_pkg::CH_G] = {1'b0, dst_px[9:5]};
      dch[rpb_pkg::CH_R] = {1'b0, dst_px[14:10]};
    end

    st_next.transparent = (src_px == 16'h0000);
    st_next.dst_px      = dst_px;
    st_next.fmt         = cfg.pixel_format;
    st_next.mode        = cfg.blend_mode;
    st_next.factor      = cfg.alpha_level[7:3];
    st_next.dch         = dch;
    for (int c = 0; c < rpb_pkg::NUM_CH; c++) begin
      st_next.diff[c] = {1'b0, sch[c]} - {1'b0, dch[c]};
      st_next.sum[c]  = {1'b0, sch[c]} + {1'b0, dch[c]};
      st_next.maxv[c] = rpb_pkg::MAX5;
    end
    if (cfg.pixel_format == rpb_pkg::FMT_565)
      st_next.maxv[rpb_pkg::CH_G] = rpb_pkg::MAX6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      st <= st_next;
    end
  end

`ifndef SYNTHESIS
  a_transp_flag: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && src_px == 16'h0000) |=> (st_valid && st.transparent))
    else $error("zero source not flagged transparent in stage 1");
`endif

endmodule

`default_nettype wire

// ===== rtl/rpb_back.sv =====
// rpb_back: pipeline stages 2 and 3, scaling/saturation then rounding,
// recombination, packing and the output register. Depends on rpb_pkg.
`default_nettype none

module rpb_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 st_valid,
  output logic                st_ready,
  input  rpb_pkg::front_t     st,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [15:0]         out_pixel,
  output logic                out_transparent
);

  logic                            mid_valid;
  logic                            mid_ready;
  logic                            out_load;
  logic                            out_fmt;
  rpb_pkg::mid_t                   mid;
  rpb_pkg::mid_t                   mid_next;
  logic signed [11:0]              opa;
  logic signed [11:0]              opb;
  logic signed [11:0]              step;
  logic [6:0]                      mixed;
  logic [rpb_pkg::NUM_CH-1:0][5:0] ch;
  logic [15:0]                     pix_next;

  assign out_load  = !out_valid || out_ready;
  assign mid_ready = out_load;
  assign st_ready  = !mid_valid || mid_ready;

  // stage 2: signed difference times factor, additive saturation
  always_comb begin
    opa = '0;
    opb = '0;
    mid_next.transparent = st.transparent;
    mid_next.dst_px      = st.dst_px;
    mid_next.fmt         = st.fmt;
    mid_next.mode        = st.mode;
    mid_next.dch         = st.dch;
    for (int c = 0; c < rpb_pkg::NUM_CH; c++) begin
      opa = {{5{st.diff[c][6]}}, st.diff[c]};
      opb = {7'b0, st.factor};
      mid_next.prod[c] = opa * opb;
      mid_next.sat[c]  = (st.sum[c] > {1'b0, st.maxv[c]}) ? st.maxv[c] : st.sum[c][5:0];
    end
  end

  // stage 3: floor(prod/32) added back to dest; result stays in range
  always_comb begin
    step  = '0;
    mixed = '0;
    for (int c = 0; c < rpb_pkg::NUM_CH; c++) begin
      step  = $signed(mid.prod[c]) >>> 5;
      mixed = {1'b0, mid.dch[c]} + step[6:0];
      ch[c] = (mid.mode == rpb_pkg::MODE_ADD) ? mid.sat[c] : mixed[5:0];
    end
    if (mid.transparent)
      pix_next = mid.dst_px;
    else if (mid.fmt == rpb_pkg::FMT_565)
      pix_next = {ch[rpb_pkg::CH_R][4:0], ch[rpb_pkg::CH_G], ch[rpb_pkg::CH_B][4:0]};
    else
      pix_next = {1'b0, ch[rpb_pkg::CH_R][4:0], ch[rpb_pkg::CH_G][4:0],
                  ch[rpb_pkg::CH_B][4:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (st_ready)
        mid_valid <= st_valid;
      if (out_load)
        out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready && st_valid)
      mid <= mid_next;
    if (out_load && mid_valid) begin
      out_pixel       <= pix_next;
      out_transparent <= mid.transparent;
      out_fmt         <= mid.fmt;
    end
  end

`ifndef SYNTHESIS
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (mid_valid && !mid_ready) |=> mid_valid)
    else $error("stage 2 transaction dropped while stalled");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (mid_valid && out_load) |=> out_valid)
    else $error("stage 2 transaction did not reach the output register");

  a_555_bit15: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_transparent && out_fmt == rpb_pkg::FMT_555) |-> !out_pixel[15])
    else $error("RGB555 blended pixel has bit 15 set");
`endif

endmodule

`default_nettype wire

// ===== rtl/rgb16_pixel_blend.sv =====
// rgb16_pixel_blend: top level of the RGB565/RGB555 alpha and additive blender.
// Depends on rpb_pkg, rpb_apb_regs, rpb_front and rpb_back.
//
//   channel   handshake              payload
//   s_*       s_tvalid / s_tready    s_tdata[15:0] source px, [31:16] destination px
//   m_*       m_tvalid / m_tready    m_tdata[15:0] out_pixel, m_tuser was_transparent
//   apb       psel, penable, pready  paddr, pwdata, prdata (regs at 0x0, 0x4, 0x8)
//
// One pixel per clock sustained while m_tready stays high; three register
// stages (unpack, multiply, recombine-and-pack): a taken input passes the
// stage 1 and stage 2 registers, and m_tvalid rises as it enters the third.
// Reset (rst, synchronous) empties the pipeline and restores RGB565, alpha
// mode and alpha level 128. Each stage holds while the one after it is full
// and stalled, so m_tready low backs up to s_tready without losing a pixel.
`default_nettype none

module rgb16_pixel_blend (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [31:0]                  s_tdata,   // [15:0] source px, [31:16] destination px
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [15:0]                  m_tdata,   // [15:0] out_pixel
  output logic                         m_tuser,   // [0] was_transparent
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [rpb_pkg::ADDR_W-1:0]   paddr,
  input  wire  [rpb_pkg::DATA_W-1:0]   pwdata,
  output logic [rpb_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  rpb_pkg::cfg_t   cfg;
  rpb_pkg::front_t st;
  logic            st_valid;
  logic            st_ready;

  rpb_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .src_px     (s_tdata[15:0]),
    .dst_px     (s_tdata[31:16]),
    .st_valid   (st_valid),
    .st_ready   (st_ready),
    .st         (st)
  );

  rpb_back u_back (
    .clk             (clk),
    .rst             (rst),
    .st_valid        (st_valid),
    .st_ready        (st_ready),
    .st              (st),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_pixel       (m_tdata),
    .out_transparent (m_tuser)
  );

endmodule

`default_nettype wire
